[src/erm_pkg.sv]
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants for the Euler-to-matrix block
// Quarter-wave sine table build, rotation order codes, trig lookup bundle.
// ----------------------------------------------------------------------------
package erm_pkg;

  // Quarter-wave table: 2^LUT_BITS + 1 entries, unsigned Q1.30 magnitudes
  localparam int LUT_BITS = 10;
  localparam int LUT_N    = 1 << LUT_BITS;
  localparam int ROM_W    = 31;
  localparam int Q_W      = 32;   // signed Q2.30 working value

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  typedef logic [ROM_W-1:0] rom_t [0:LUT_N];

  // Rotation order; the two unused codes fall back to XYZ
  typedef enum logic [2:0] {
    MODE_XYZ = 3'd0,
    MODE_YXZ = 3'd1,
    MODE_ZXY = 3'd2,
    MODE_ZYX = 3'd3,
    MODE_YZX = 3'd4,
    MODE_XZY = 3'd5
  } mode_t;

  // Registered sine/cosine lookup of one angle
  typedef struct packed {
    logic [ROM_W-1:0] sin_mag;
    logic             sin_neg;
    logic [ROM_W-1:0] cos_mag;
    logic             cos_neg;
  } trig_t;

  // Sine over one quarter turn by a 10-term Taylor series in Q30 integers.
  // Evaluated at elaboration only.
  function automatic rom_t sine_rom_build();
    rom_t               rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int i = 0; i <= LUT_N; i++) begin
      x    = (64'(i) * HALF_PI_Q30) >> LUT_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 9; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) != 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      rom[i] = ROM_W'(sum);
    end
    return rom;
  endfunction

endpackage

[src/euler_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: three binary angles and a rotation order in,
// nine entries of the 3x3 rotation matrix out, signed Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
// Depth: eight register stages; the first loads at the input transfer edge.
// Throughput: one item per cycle unless result_ready stalls the output;
//   every stage has its own valid bit and loads whenever it is empty or
//   its successor loads, so bubbles close up.
// Reset: clears the stage valid bits only; the sine table is constant logic.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [ANGLE_BITS-1:0] angle_x,
  input  logic [ANGLE_BITS-1:0] angle_y,
  input  logic [ANGLE_BITS-1:0] angle_z,
  input  logic [2:0]            mode,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic signed [15:0]    m00,
  output logic signed [15:0]    m10,
  output logic signed [15:0]    m20,
  output logic signed [15:0]    m01,
  output logic signed [15:0]    m11,
  output logic signed [15:0]    m21,
  output logic signed [15:0]    m02,
  output logic signed [15:0]    m12,
  output logic signed [15:0]    m22
);

  localparam int QW    = erm_pkg::Q_W;
  localparam int PW    = 2 * QW;
  localparam int SW    = QW + 1;     // sum of two Q30 terms
  localparam int OSH   = 30 - FRAC_BITS;
  localparam logic signed [SW:0] OHALF = (SW+1)'((64'(1) << OSH) >> 1);
  localparam logic signed [SW:0] OLIM  = (SW+1)'(64'(1) << FRAC_BITS);
  localparam logic signed [PW-1:0] QHALF = PW'(64'(1) << 29);

  // Stage map:
  //  1  table reads (in erm_sincos)
  //  2  sign applied: a=cos x, b=sin x, c=cos y, d=sin y, e=cos z, f=sin z
  //  3  eight first-level products, operands picked by order group
  //  4  round first-level products to Q30
  //  5  four second-level products: the pair products times g
  //  6  round second-level products
  //  7  add/subtract per order into the nine entries
  //  8  round to Q1.FRAC_BITS, saturate to +/-1.0, output register
  //
  // Order groups share one product layout:
  //  XYZ/ZYX: q = ae af be bf ce cf bc ac, g = d
  //  YXZ/ZXY: q = ce cf de df ad af ae ac, g = b
  //  YZX/XZY: q = ac ad bc bd ce ae de be, g = f
  //  r[k] = q[k] * g for k = 0..3 in every group.

  logic [8:1] v;
  logic [8:1] en;

  // ---- handshake: a stage loads when empty or when the next one loads
  always_comb begin
    en[8] = !v[8] || result_ready;
    for (int s = 7; s >= 1; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign item_ready   = en[1];
  assign result_valid = v[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= item_valid;
      end
      for (int s = 2; s <= 8; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // ---- stage 1: sine/cosine lookups
  erm_pkg::trig_t trig_x;
  erm_pkg::trig_t trig_y;
  erm_pkg::trig_t trig_z;
  logic [2:0]     mode1;

  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_x (
    .clk(clk), .en(en[1]), .angle(angle_x), .trig(trig_x)
  );
  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_y (
    .clk(clk), .en(en[1]), .angle(angle_y), .trig(trig_y)
  );
  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_z (
    .clk(clk), .en(en[1]), .angle(angle_z), .trig(trig_z)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode1 <= mode;
    end
  end

  // ---- stage 2: signed Q30 sines and cosines
  function automatic logic signed [QW-1:0] signed_q30(
    input logic [erm_pkg::ROM_W-1:0] mag,
    input logic                      neg
  );
    logic signed [QW-1:0] pos;
    pos = signed'(QW'(mag));
    return neg ? -pos : pos;
  endfunction

  logic signed [QW-1:0] a2, b2, c2, d2, e2, f2;
  logic [2:0]           mode2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a2    <= signed_q30(trig_x.cos_mag, trig_x.cos_neg);
      b2    <= signed_q30(trig_x.sin_mag, trig_x.sin_neg);
      c2    <= signed_q30(trig_y.cos_mag, trig_y.cos_neg);
      d2    <= signed_q30(trig_y.sin_mag, trig_y.sin_neg);
      e2    <= signed_q30(trig_z.cos_mag, trig_z.cos_neg);
      f2    <= signed_q30(trig_z.sin_mag, trig_z.sin_neg);
      mode2 <= mode1;
    end
  end

  // ---- stage 3: first-level products
  logic signed [QW-1:0] opl [8];
  logic signed [QW-1:0] opr [8];
  logic signed [QW-1:0] g2;

  always_comb begin
    case (erm_pkg::mode_t'(mode2)) inside
      erm_pkg::MODE_YXZ, erm_pkg::MODE_ZXY: begin
        opl = '{c2, c2, d2, d2, a2, a2, a2, a2};
        opr = '{e2, f2, e2, f2, d2, f2, e2, c2};
        g2  = b2;
      end
      erm_pkg::MODE_YZX, erm_pkg::MODE_XZY: begin
        opl = '{a2, a2, b2, b2, c2, a2, d2, b2};
        opr = '{c2, d2, c2, d2, e2, e2, e2, e2};
        g2  = f2;
      end
      default: begin
        opl = '{a2, a2, b2, b2, c2, c2, b2, a2};
        opr = '{e2, f2, e2, f2, e2, f2, c2, c2};
        g2  = d2;
      end
    endcase
  end

  logic signed [PW-1:0] prod3 [8];
  logic signed [QW-1:0] g3;
  logic [2:0]           mode3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 8; k++) begin
        prod3[k] <= opl[k] * opr[k];
      end
      g3    <= g2;
      mode3 <= mode2;
    end
  end

  // ---- stage 4: round half up, floor by 2^30
  function automatic logic signed [QW-1:0] round_q30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + QHALF) >>> 30;
    return QW'(t);
  endfunction

  logic signed [QW-1:0] q4 [8];
  logic signed [QW-1:0] g4;
  logic [2:0]           mode4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 8; k++) begin
        q4[k] <= round_q30(prod3[k]);
      end
      g4    <= g3;
      mode4 <= mode3;
    end
  end

  // ---- stage 5: second-level products
  logic signed [PW-1:0] prod5 [4];
  logic signed [QW-1:0] q5 [8];
  logic signed [QW-1:0] g5;
  logic [2:0]           mode5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 4; k++) begin
        prod5[k] <= q4[k] * g4;
      end
      q5    <= q4;
      g5    <= g4;
      mode5 <= mode4;
    end
  end

  // ---- stage 6: round second-level products
  logic signed [QW-1:0] r6 [4];
  logic signed [QW-1:0] q6 [8];
  logic signed [QW-1:0] g6;
  logic [2:0]           mode6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < 4; k++) begin
        r6[k] <= round_q30(prod5[k]);
      end
      q6    <= q5;
      g6    <= g5;
      mode6 <= mode5;
    end
  end

  // ---- stage 7: combine; entry order m00 m10 m20 m01 m11 m21 m02 m12 m22
  function automatic logic signed [SW-1:0] ext(input logic signed [QW-1:0] x);
    return SW'(x);
  endfunction

  logic signed [SW-1:0] sum7 [9];

  always_comb begin
    case (erm_pkg::mode_t'(mode6))
      erm_pkg::MODE_YXZ: begin
        sum7[0] = ext(q6[0]) + ext(r6[3]);
        sum7[1] = ext(q6[5]);
        sum7[2] = ext(r6[1]) - ext(q6[2]);
        sum7[3] = ext(r6[2]) - ext(q6[1]);
        sum7[4] = ext(q6[6]);
        sum7[5] = ext(q6[3]) + ext(r6[0]);
        sum7[6] = ext(q6[4]);
        sum7[7] = -ext(g6);
        sum7[8] = ext(q6[7]);
      end
      erm_pkg::MODE_ZXY: begin
        sum7[0] = ext(q6[0]) - ext(r6[3]);
        sum7[1] = ext(q6[1]) + ext(r6[2]);
        sum7[2] = -ext(q6[4]);
        sum7[3] = -ext(q6[5]);
        sum7[4] = ext(q6[6]);
        sum7[5] = ext(g6);
        sum7[6] = ext(q6[2]) + ext(r6[1]);
        sum7[7] = ext(q6[3]) - ext(r6[0]);
        sum7[8] = ext(q6[7]);
      end
      erm_pkg::MODE_ZYX: begin
        sum7[0] = ext(q6[4]);
        sum7[1] = ext(q6[5]);
        sum7[2] = -ext(g6);
        sum7[3] = ext(r6[2]) - ext(q6[1]);
        sum7[4] = ext(r6[3]) + ext(q6[0]);
        sum7[5] = ext(q6[6]);
        sum7[6] = ext(r6[0]) + ext(q6[3]);
        sum7[7] = ext(r6[1]) - ext(q6[2]);
        sum7[8] = ext(q6[7]);
      end
      erm_pkg::MODE_YZX: begin
        sum7[0] = ext(q6[4]);
        sum7[1] = ext(g6);
        sum7[2] = -ext(q6[6]);
        sum7[3] = ext(q6[3]) - ext(r6[0]);
        sum7[4] = ext(q6[5]);
        sum7[5] = ext(r6[1]) + ext(q6[2]);
        sum7[6] = ext(r6[2]) + ext(q6[1]);
        sum7[7] = -ext(q6[7]);
        sum7[8] = ext(q6[0]) - ext(r6[3]);
      end
      erm_pkg::MODE_XZY: begin
        sum7[0] = ext(q6[4]);
        sum7[1] = ext(r6[0]) + ext(q6[3]);
        sum7[2] = ext(r6[2]) - ext(q6[1]);
        sum7[3] = -ext(g6);
        sum7[4] = ext(q6[5]);
        sum7[5] = ext(q6[7]);
        sum7[6] = ext(q6[6]);
        sum7[7] = ext(r6[1]) - ext(q6[2]);
        sum7[8] = ext(r6[3]) + ext(q6[0]);
      end
      default: begin   // XYZ, also the two unused codes
        sum7[0] = ext(q6[4]);
        sum7[1] = ext(q6[1]) + ext(r6[2]);
        sum7[2] = ext(q6[3]) - ext(r6[0]);
        sum7[3] = -ext(q6[5]);
        sum7[4] = ext(q6[0]) - ext(r6[3]);
        sum7[5] = ext(q6[2]) + ext(r6[1]);
        sum7[6] = ext(g6);
        sum7[7] = -ext(q6[6]);
        sum7[8] = ext(q6[7]);
      end
    endcase
  end

  logic signed [SW-1:0] m7 [9];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      m7 <= sum7;
    end
  end

  // ---- stage 8: Q30 -> Q1.FRAC_BITS, round half up, saturate, keep 16 bits
  function automatic logic signed [15:0] to_out(input logic signed [SW-1:0] x);
    logic signed [SW:0] t;
    t = ((SW+1)'(x) + OHALF) >>> OSH;
    if (t > OLIM) begin
      t = OLIM;
    end
    if (t < -OLIM) begin
      t = -OLIM;
    end
    return 16'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (en[8]) begin
      m00 <= to_out(m7[0]);
      m10 <= to_out(m7[1]);
      m20 <= to_out(m7[2]);
      m01 <= to_out(m7[3]);
      m11 <= to_out(m7[4]);
      m21 <= to_out(m7[5]);
      m02 <= to_out(m7[6]);
      m12 <= to_out(m7[7]);
      m22 <= to_out(m7[8]);
    end
  end

endmodule

[src/erm_sincos.sv]
// ----------------------------------------------------------------------------
// erm_sincos: sine and cosine of one binary angle
// Quadrant fold, nearest-entry index and a two-port read of the quarter-wave
// table; magnitudes and signs come out registered.
// ----------------------------------------------------------------------------
module erm_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output erm_pkg::trig_t        trig
);

  localparam int QB = ANGLE_BITS - 2;
  localparam int IW = erm_pkg::LUT_BITS + 1;
  localparam erm_pkg::rom_t ROM = erm_pkg::sine_rom_build();

  logic [ANGLE_BITS-1:0] cos_angle;
  logic [QB-1:0]         sin_p;
  logic [QB-1:0]         cos_p;
  logic [IW-1:0]         sin_pos;
  logic [IW-1:0]         cos_pos;
  logic [IW-1:0]         sin_idx;
  logic [IW-1:0]         cos_idx;

  // cos(t) = sin(t + quarter turn)
  assign cos_angle = angle + ANGLE_BITS'(1 << QB);
  assign sin_p     = angle[QB-1:0];
  assign cos_p     = cos_angle[QB-1:0];

  generate
    if (QB >= erm_pkg::LUT_BITS) begin : g_round
      localparam int SH = QB - erm_pkg::LUT_BITS;
      localparam logic [QB:0] HALF = (QB+1)'((1 << SH) >> 1);
      assign sin_pos = IW'(({1'b0, sin_p} + HALF) >> SH);
      assign cos_pos = IW'(({1'b0, cos_p} + HALF) >> SH);
    end else begin : g_expand
      assign sin_pos = IW'(sin_p) << (erm_pkg::LUT_BITS - QB);
      assign cos_pos = IW'(cos_p) << (erm_pkg::LUT_BITS - QB);
    end
  endgenerate

  // odd quadrants run the table backwards
  assign sin_idx = angle[QB]     ? IW'(erm_pkg::LUT_N) - sin_pos : sin_pos;
  assign cos_idx = cos_angle[QB] ? IW'(erm_pkg::LUT_N) - cos_pos : cos_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      trig.sin_mag <= ROM[sin_idx];
      trig.cos_mag <= ROM[cos_idx];
      trig.sin_neg <= angle[QB+1];
      trig.cos_neg <= cos_angle[QB+1];
    end
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for euler_to_rotation_matrix
// Drives three binary angles plus a rotation order over a valid/ready
// channel and checks every 3x3 result against an in-bench fixed-point
// predictor. The run covers a short directed table, then random angles
// under three idling profiles, a long output back-pressure stretch and a
// full drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_W      = 16;
  localparam int FRAC_W       = 14;
  localparam int PIPE_LATENCY = 8;
  localparam int LONG_STALL   = 80;    // receiver hold-off, well past pipeline depth
  localparam int RAND_ITEMS   = 1780;

  // order codes the enum leaves out; the block treats both as XYZ
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  // matrix entries, index j = m00 m10 m20 m01 m11 m21 m02 m12 m22
  typedef logic [8:0][15:0] mat_t;

  localparam logic [15:0] POS_ONE = 16'h4000;   // +1.0 in Q1.14
  localparam logic [15:0] NEG_ONE = 16'hC000;   // -1.0 in Q1.14
  localparam mat_t IDENT   = {POS_ONE, 16'h0, 16'h0, 16'h0, POS_ONE, 16'h0, 16'h0, 16'h0,
                              POS_ONE};
  // half turn about X: diag(1, -1, -1) for every order
  localparam mat_t X_FLIP  = {NEG_ONE, 16'h0, 16'h0, 16'h0, NEG_ONE, 16'h0, 16'h0, 16'h0,
                              POS_ONE};

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [2:0]  md;
    logic        known;   // expected matrix typed in below
    mat_t        mat;
  } dir_row_t;

  localparam int N_DIRECTED = 23;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // zero angles give the identity in every order, spare codes included
    '{16'h0000, 16'h0000, 16'h0000, erm_pkg::MODE_XYZ, 1'b1, IDENT},
    '{16'h0000, 16'h0000, 16'h0000, erm_pkg::MODE_YXZ, 1'b1, IDENT},
    '{16'h0000, 16'h0000, 16'h0000, erm_pkg::MODE_ZXY, 1'b1, IDENT},
    '{16'h0000, 16'h0000, 16'h0000, erm_pkg::MODE_ZYX, 1'b1, IDENT},
    '{16'h0000, 16'h0000, 16'h0000, erm_pkg::MODE_YZX, 1'b1, IDENT},
    '{16'h0000, 16'h0000, 16'h0000, erm_pkg::MODE_XZY, 1'b1, IDENT},
    '{16'h0000, 16'h0000, 16'h0000, MODE_SPARE6,       1'b1, IDENT},
    '{16'h0000, 16'h0000, 16'h0000, MODE_SPARE7,       1'b1, IDENT},
    // half turn about X, saturating -1.0 on the diagonal
    '{16'h8000, 16'h0000, 16'h0000, erm_pkg::MODE_XYZ, 1'b1, X_FLIP},
    '{16'h8000, 16'h0000, 16'h0000, erm_pkg::MODE_ZYX, 1'b1, X_FLIP},
    '{16'h8000, 16'h0000, 16'h0000, MODE_SPARE7,       1'b1, X_FLIP},
    // all-ones angles, every order
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, erm_pkg::MODE_XYZ, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, erm_pkg::MODE_YXZ, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, erm_pkg::MODE_ZXY, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, erm_pkg::MODE_ZYX, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, erm_pkg::MODE_YZX, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, erm_pkg::MODE_XZY, 1'b0, '0},
    // quarter turns on each axis, then a mix of quarter and half turns
    '{16'h4000, 16'h0000, 16'h0000, erm_pkg::MODE_XYZ, 1'b0, '0},
    '{16'h0000, 16'h4000, 16'h0000, erm_pkg::MODE_YXZ, 1'b0, '0},
    '{16'h0000, 16'h0000, 16'h4000, erm_pkg::MODE_ZXY, 1'b0, '0},
    '{16'hC000, 16'h4000, 16'h8000, erm_pkg::MODE_YZX, 1'b0, '0},
    // half-step rounding of the table index, spare code with real angles
    '{16'h0008, 16'h3FF8, 16'hBFF7, erm_pkg::MODE_XZY, 1'b0, '0},
    '{16'h2AAA, 16'h5555, 16'hD555, MODE_SPARE6,       1'b0, '0}
  };

  string entry_name [9] = '{"m00", "m10", "m20", "m01", "m11", "m21", "m02", "m12", "m22"};

  // --------------------------------------------------------------------------
  // DUT signals: every input starts at a known value
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [ANGLE_W-1:0]  angle_x = '0;
  logic [ANGLE_W-1:0]  angle_y = '0;
  logic [ANGLE_W-1:0]  angle_z = '0;
  logic [2:0]          mode = erm_pkg::MODE_XYZ;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic signed [15:0]  m00, m10, m20, m01, m11, m21, m02, m12, m22;

  // travels with the payload so the monitor knows a typed-in expectation
  logic                row_known = 1'b0;
  mat_t                row_mat = '0;

  // bench state
  logic signed [63:0]  sine_tab [0:erm_pkg::LUT_N];   // quarter-wave sine, Q2.30
  mat_t                matrix_q [$];         // expected matrices, oldest first
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  bit                  stall_request = 1'b0;
  int                  fail_count = 0;
  int                  results_seen = 0;
  int                  items_sent = 0;

  euler_to_rotation_matrix #(
    .ANGLE_BITS (ANGLE_W),
    .FRAC_BITS  (FRAC_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .angle_x      (angle_x),
    .angle_y      (angle_y),
    .angle_z      (angle_z),
    .mode         (mode),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .m00          (m00),
    .m10          (m10),
    .m20          (m20),
    .m01          (m01),
    .m11          (m11),
    .m21          (m21),
    .m02          (m02),
    .m12          (m12),
    .m22          (m22)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop; a correct run finishes in well under a tenth of this.
  initial begin
    #2_000_000;
    $display("Timeout at %0t: %0d expected matrices still outstanding",
             $time, matrix_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Q30 x Q30 -> Q30, round half up; >>> on signed is a floor shift
  function automatic logic signed [63:0] qmul(input logic signed [63:0] p,
                                              input logic signed [63:0] q);
    return (p * q + 64'sd536870912) >>> 30;
  endfunction

  // nearest table entry; quadrant bits pick mirror and sign
  function automatic logic signed [63:0] sine_q30(input logic [ANGLE_W-1:0] ang);
    int unsigned idx;
    idx = (int'(ang[13:0]) + 8) >> 4;
    if (idx > erm_pkg::LUT_N) begin
      idx = erm_pkg::LUT_N;
    end
    if (ang[14]) begin
      idx = erm_pkg::LUT_N - idx;
    end
    return ang[15] ? -sine_tab[idx] : sine_tab[idx];
  endfunction

  // Q2.30 -> Q1.14 with round half up, clamp to +/-1.0
  function automatic logic [15:0] to_q14(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) begin
      r = 64'sd16384;
    end
    if (r < -64'sd16384) begin
      r = -64'sd16384;
    end
    return r[15:0];
  endfunction

  function automatic mat_t rotation_matrix(input logic [ANGLE_W-1:0] ax,
                                           input logic [ANGLE_W-1:0] ay,
                                           input logic [ANGLE_W-1:0] az,
                                           input logic [2:0]         md);
    logic signed [63:0] cx, sx, cy, sy, cz, sz;
    logic signed [63:0] ae, af, be, bf, ce, cf, de, df, ac, ad, bc, bd;
    logic signed [63:0] m [9];
    mat_t               res;
    cx = sine_q30(ax + 16'h4000);  sx = sine_q30(ax);
    cy = sine_q30(ay + 16'h4000);  sy = sine_q30(ay);
    cz = sine_q30(az + 16'h4000);  sz = sine_q30(az);
    ae = qmul(cx, cz);  af = qmul(cx, sz);  be = qmul(sx, cz);  bf = qmul(sx, sz);
    ce = qmul(cy, cz);  cf = qmul(cy, sz);  de = qmul(sy, cz);  df = qmul(sy, sz);
    ac = qmul(cx, cy);  ad = qmul(cx, sy);  bc = qmul(sx, cy);  bd = qmul(sx, sy);
    case (md)
      erm_pkg::MODE_YXZ: begin
        m[0] = ce + qmul(df, sx);  m[3] = qmul(de, sx) - cf;  m[6] = qmul(cx, sy);
        m[1] = qmul(cx, sz);       m[4] = qmul(cx, cz);       m[7] = -sx;
        m[2] = qmul(cf, sx) - de;  m[5] = df + qmul(ce, sx);  m[8] = qmul(cx, cy);
      end
      erm_pkg::MODE_ZXY: begin
        m[0] = ce - qmul(df, sx);  m[3] = -qmul(cx, sz);      m[6] = de + qmul(cf, sx);
        m[1] = cf + qmul(de, sx);  m[4] = qmul(cx, cz);       m[7] = df - qmul(ce, sx);
        m[2] = -qmul(cx, sy);      m[5] = sx;                 m[8] = qmul(cx, cy);
      end
      erm_pkg::MODE_ZYX: begin
        m[0] = qmul(cy, cz);       m[3] = qmul(be, sy) - af;  m[6] = qmul(ae, sy) + bf;
        m[1] = qmul(cy, sz);       m[4] = qmul(bf, sy) + ae;  m[7] = qmul(af, sy) - be;
        m[2] = -sy;                m[5] = qmul(sx, cy);       m[8] = qmul(cx, cy);
      end
      erm_pkg::MODE_YZX: begin
        m[0] = qmul(cy, cz);       m[3] = bd - qmul(ac, sz);  m[6] = qmul(bc, sz) + ad;
        m[1] = sz;                 m[4] = qmul(cx, cz);       m[7] = -qmul(sx, cz);
        m[2] = -qmul(sy, cz);      m[5] = qmul(ad, sz) + bc;  m[8] = ac - qmul(bd, sz);
      end
      erm_pkg::MODE_XZY: begin
        m[0] = qmul(cy, cz);       m[3] = -sz;                m[6] = qmul(sy, cz);
        m[1] = qmul(ac, sz) + bd;  m[4] = qmul(cx, cz);       m[7] = qmul(ad, sz) - bc;
        m[2] = qmul(bc, sz) - ad;  m[5] = qmul(sx, cz);       m[8] = qmul(bd, sz) + ac;
      end
      default: begin   // XYZ and the spare codes
        m[0] = qmul(cy, cz);       m[3] = -qmul(cy, sz);      m[6] = sy;
        m[1] = af + qmul(be, sy);  m[4] = ae - qmul(bf, sy);  m[7] = -qmul(sx, cy);
        m[2] = bf - qmul(ae, sy);  m[5] = be + qmul(af, sy);  m[8] = qmul(cx, cy);
      end
    endcase
    for (int j = 0; j < 9; j++) begin
      res[j] = to_q14(m[j]);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: expectation at input transfer, check at output transfer.
  // Runs at the edge, so it sees the values that the transfer used.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    mat_t want;
    mat_t got;
    if (!rst && item_valid && item_ready) begin
      matrix_q.push_back(row_known ? row_mat
                                   : rotation_matrix(angle_x, angle_y, angle_z, mode));
    end
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      got = {m22, m12, m02, m21, m11, m01, m20, m10, m00};
      if (matrix_q.size() == 0) begin
        fail_count++;
        $display("%0t: result transfer with no matrix expected", $time);
      end else begin
        want = matrix_q.pop_front();
        for (int j = 0; j < 9; j++) begin
          if (got[j] !== want[j]) begin
            fail_count++;
            $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
                     $time, results_seen, entry_name[j],
                     $signed(want[j]), $signed(got[j]));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = LONG_STALL;
      end
      if (rst) begin
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Called just after an edge. Idles at random, then offers the item and
  // holds it until the transfer edge.
  task automatic send_item(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                           input logic [ANGLE_W-1:0] az, input logic [2:0] md,
                           input logic known, input mat_t want);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    angle_x    <= ax;
    angle_y    <= ay;
    angle_z    <= az;
    mode       <= md;
    row_known  <= known;
    row_mat    <= want;
    do begin
      @(posedge clk);
    end while (!item_ready);
    items_sent++;
  endtask

  // Mostly uniform; the rest sits near a quadrant edge where the table
  // index mirrors and the rounding crosses into the next entry.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] base;
    if ($urandom_range(9) < 7) begin
      return ANGLE_W'($urandom);
    end
    base = {2'($urandom_range(3)), 14'h0};
    return base + ANGLE_W'($urandom_range(32)) - ANGLE_W'(16);
  endfunction

  // Called just after an edge; returns once every expected matrix is in.
  task automatic drain();
    @(posedge clk);
    while (matrix_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    logic [63:0]        x, x2, term;
    logic signed [63:0] acc;
    int                 per_phase;

    // Quarter-wave sine table: 10-term Taylor series in Q30 integers
    for (int i = 0; i <= erm_pkg::LUT_N; i++) begin
      x    = (64'(i) * 64'd1686629713) >> erm_pkg::LUT_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      for (int k = 1; k <= 9; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - signed'(term);
        end else begin
          acc = acc + signed'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > 64'sd1073741824) begin
        acc = 64'sd1073741824;
      end
      sine_tab[i] = acc;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, no idling
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_item(DIRECTED[r].ax, DIRECTED[r].ay, DIRECTED[r].az, DIRECTED[r].md,
                DIRECTED[r].known, DIRECTED[r].mat);
    end

    // Random angles under three idling profiles
    per_phase = RAND_ITEMS / 3;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 32; recv_idle_pct = 59; end
        1:       begin send_idle_pct = 59; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        // last phase: fill the pipe against a held-off receiver, later
        // pause input until everything in flight is out
        if (ph == 2 && n == 150) begin
          stall_request = 1'b1;
        end
        if (ph == 2 && n == 400) begin
          item_valid <= 1'b0;
          drain();
        end
        send_item(pick_angle(), pick_angle(), pick_angle(), 3'($urandom_range(7)),
                  1'b0, '0);
      end
    end

    item_valid <= 1'b0;
    row_known  <= 1'b0;
    drain();
    repeat (2 * PIPE_LATENCY + 4) @(posedge clk);

    $display("Covered %0d matrices (directed table plus random angles, all eight order codes)",
             items_sent);
    $display("three idling profiles, a %0d-cycle output hold-off, a full drain; %0d %s %0d",
             LONG_STALL, results_seen, "results checked, mismatches:", fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
